[rtl/core/ffba_pkg.sv]
// Shared types, codes and default sizes for the first-fit block allocator.
package ffba_pkg;

    // Default arena geometry, handed to the top level as parameter defaults.
    localparam int ARENA_BYTES_DEF  = 4096;
    localparam int HEADER_BYTES_DEF = 16;

    // Fixed field widths.
    localparam int REQ_W    = 12;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;

    typedef logic [STATUS_W-1:0] status_t;

    // Result status codes.
    localparam status_t ST_DONE    = 2'd0;
    localparam status_t ST_NOSPACE = 2'd1;
    localparam status_t ST_REJECT  = 2'd2;

    // Request command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the request, restart the walk at offset 0
        logic step;     // advance the walk to the next header
        logic take;     // claim the header under the walk
        logic split;    // write the split remainder header, if any
        logic append;   // append a block at the arena end, or fail
        logic free_op;  // execute a free request
        logic publish;  // move the pending result to the output register
        logic cfg_wr;   // write heap_key and empty the arena
    } ffba_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_free;   // captured request is a free
        logic in_chain;  // walk position is below the arena end
        logic fit;       // header under the walk satisfies the request
    } ffba_sts_t;

endpackage

[rtl/core/ffba_dpath.sv]
// Datapath of the allocator: request registers, header memories, walk and results.
module ffba_dpath #(
    parameter int ARENA_BYTES  = ffba_pkg::ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ffba_pkg::ffba_cmd_t                cmd_in,
    output ffba_pkg::ffba_sts_t                sts,
    input  logic                               cmd,
    input  logic [ffba_pkg::REQ_W-1:0]         request_size,
    input  logic [ffba_pkg::KEY_W-1:0]         pointer_key,
    input  logic [$clog2(ARENA_BYTES):0]       pointer_offset,
    input  logic [ffba_pkg::KEY_W-1:0]         cfg_data,
    output ffba_pkg::status_t                  status,
    output logic [$clog2(ARENA_BYTES):0]       block_offset,
    output logic [ffba_pkg::KEY_W-1:0]         block_key
);

    localparam int ADDR_W = $clog2(ARENA_BYTES);
    localparam int POS_W  = ADDR_W + 1;
    localparam int REQ_W  = ffba_pkg::REQ_W;
    localparam int KEY_W  = ffba_pkg::KEY_W;
    localparam int CMP_W  = ((POS_W > REQ_W) ? POS_W : REQ_W) + 2;
    localparam logic [CMP_W-1:0] HDR_C   = CMP_W'(HEADER_BYTES);
    localparam logic [CMP_W-1:0] ARENA_C = CMP_W'(ARENA_BYTES);

    // Captured request.
    logic               op_reg;
    logic [REQ_W-1:0]   req_reg;
    logic [KEY_W-1:0]   pkey_reg;
    logic [POS_W-1:0]   poff_reg;

    // Walk and arena state.
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   end_reg, end_next;
    logic [KEY_W-1:0]   key_reg, key_next;

    // Header memories and their registered read data.
    logic [ADDR_W-1:0]  size_mem [ARENA_BYTES];
    logic               used_mem [ARENA_BYTES];
    logic [ADDR_W-1:0]  size_rd_reg;
    logic               used_rd_reg;

    // Pending split header.
    logic [ADDR_W-1:0]  split_addr_reg;
    logic [ADDR_W-1:0]  split_size_reg;
    logic               split_en_reg;

    // Pending result and output register.
    ffba_pkg::status_t  res_status_reg, res_status_next;
    logic [POS_W-1:0]   res_offset_reg, res_offset_next;
    logic [KEY_W-1:0]   res_key_reg, res_key_next;
    ffba_pkg::status_t  out_status_reg;
    logic [POS_W-1:0]   out_offset_reg;
    logic [KEY_W-1:0]   out_key_reg;

    // Widened operands for compares and sums.
    logic [CMP_W-1:0]   pos_w, req_w, size_w, end_w, poff_w;
    logic [CMP_W-1:0]   walk_w, split_w, pay_w, app_pay_w, app_end_w, free_pos_w;
    logic               split_ok, append_ok, free_hit, free_reject;

    // Memory write ports.
    logic               size_we, used_we, used_wd;
    logic [ADDR_W-1:0]  size_wa, size_wd, used_wa;

    assign pos_w  = CMP_W'(pos_reg);
    assign req_w  = CMP_W'(req_reg);
    assign size_w = CMP_W'(size_rd_reg);
    assign end_w  = CMP_W'(end_reg);
    assign poff_w = CMP_W'(poff_reg);

    assign walk_w     = pos_w + HDR_C + size_w;
    assign split_w    = pos_w + HDR_C + req_w;
    assign pay_w      = pos_w + HDR_C;
    assign app_pay_w  = end_w + HDR_C;
    assign app_end_w  = end_w + HDR_C + req_w;
    assign free_pos_w = poff_w - HDR_C;

    assign split_ok    = split_w < ARENA_C;
    assign append_ok   = (req_w + HDR_C) <= (ARENA_C - end_w);
    assign free_hit    = (poff_w >= HDR_C) && (free_pos_w < ARENA_C);
    assign free_reject = ((pkey_reg == '0) && (poff_reg == '0)) || (pkey_reg != key_reg);

    // Status toward the controller.
    assign sts.is_free  = (op_reg == ffba_pkg::CMD_FREE);
    assign sts.in_chain = pos_reg < end_reg;
    assign sts.fit      = !used_rd_reg && ((size_w == req_w) || (size_w >= req_w + HDR_C));

    // Capture the request.
    always_ff @(posedge clk)
    begin
        if (cmd_in.load)
        begin
            op_reg   <= cmd;
            req_reg  <= request_size;
            pkey_reg <= pointer_key;
            poff_reg <= pointer_offset;
        end
    end

    // Walk position: restart at zero, or step past the current block.
    // A step that would leave the arena parks at the arena size, which ends the walk.
    always_comb
    begin
        pos_next = pos_reg;
        if (cmd_in.load)
        begin
            pos_next = '0;
        end
        else if (cmd_in.step)
        begin
            pos_next = (walk_w >= ARENA_C) ? POS_W'(ARENA_BYTES) : walk_w[POS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
    end

    // Heap key and arena end.
    always_comb
    begin
        key_next = key_reg;
        end_next = end_reg;
        if (cmd_in.cfg_wr)
        begin
            key_next = cfg_data;
            end_next = '0;
        end
        else if (cmd_in.append && append_ok)
        begin
            end_next = app_end_w[POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            end_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
            end_reg <= end_next;
        end
    end

    // Memory write port selection.
    always_comb
    begin
        size_we = 1'b0;
        size_wa = pos_reg[ADDR_W-1:0];
        size_wd = ADDR_W'(req_reg);
        used_we = 1'b0;
        used_wa = pos_reg[ADDR_W-1:0];
        used_wd = 1'b1;
        priority if (cmd_in.take)
        begin
            size_we = 1'b1;
            used_we = 1'b1;
        end
        else if (cmd_in.split)
        begin
            size_we = split_en_reg;
            size_wa = split_addr_reg;
            size_wd = split_size_reg;
            used_we = split_en_reg;
            used_wa = split_addr_reg;
            used_wd = 1'b0;
        end
        else if (cmd_in.append)
        begin
            size_we = append_ok;
            size_wa = end_reg[ADDR_W-1:0];
            used_we = append_ok;
            used_wa = end_reg[ADDR_W-1:0];
        end
        else if (cmd_in.free_op)
        begin
            used_we = !free_reject && free_hit;
            used_wa = free_pos_w[ADDR_W-1:0];
            used_wd = 1'b0;
        end
    end

    // Header size memory: one write port, one registered read at the walk position.
    always_ff @(posedge clk)
    begin
        if (size_we)
        begin
            size_mem[size_wa] <= size_wd;
        end
        size_rd_reg <= size_mem[pos_reg[ADDR_W-1:0]];
    end

    // In-use mark memory: same arrangement.
    always_ff @(posedge clk)
    begin
        if (used_we)
        begin
            used_mem[used_wa] <= used_wd;
        end
        used_rd_reg <= used_mem[pos_reg[ADDR_W-1:0]];
    end

    // Remember the split remainder when a larger free block is claimed.
    always_ff @(posedge clk)
    begin
        if (cmd_in.take)
        begin
            split_addr_reg <= split_w[ADDR_W-1:0];
            split_size_reg <= ADDR_W'(size_w - req_w - HDR_C);
            split_en_reg   <= (size_w != req_w) && split_ok;
        end
    end

    // Pending result.
    always_comb
    begin
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        res_key_next    = res_key_reg;
        if (cmd_in.take)
        begin
            res_status_next = ffba_pkg::ST_DONE;
            res_offset_next = pay_w[POS_W-1:0];
            res_key_next    = key_reg;
        end
        else if (cmd_in.append)
        begin
            res_status_next = append_ok ? ffba_pkg::ST_DONE : ffba_pkg::ST_NOSPACE;
            res_offset_next = append_ok ? app_pay_w[POS_W-1:0] : '0;
            res_key_next    = append_ok ? key_reg : '0;
        end
        else if (cmd_in.free_op)
        begin
            res_status_next = free_reject ? ffba_pkg::ST_REJECT : ffba_pkg::ST_DONE;
            res_offset_next = '0;
            res_key_next    = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        res_key_reg    <= res_key_next;
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (cmd_in.publish)
        begin
            out_status_reg <= res_status_reg;
            out_offset_reg <= res_offset_reg;
            out_key_reg    <= res_key_reg;
        end
    end

    assign status       = out_status_reg;
    assign block_offset = out_offset_reg;
    assign block_key    = out_key_reg;

    // A block is only claimed at a header inside the chain.
    a_take_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_in.take |-> (pos_reg < end_reg))
        else $error("header claimed outside the block chain");

    // The arena end never passes the arena size.
    a_end_bound: assert property (@(posedge clk) disable iff (!rst_n)
        end_reg <= POS_W'(ARENA_BYTES))
        else $error("arena end beyond arena size");

    // A successful append always moves the arena end forward.
    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_in.append && append_ok && !cmd_in.cfg_wr) |=> (end_reg > $past(end_reg)))
        else $error("append did not advance the arena end");

endmodule

[rtl/core/ffba_ctrl.sv]
// Controller state machine of the allocator: handshakes and walk sequencing.
module ffba_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  ffba_pkg::ffba_sts_t  sts,
    output ffba_pkg::ffba_cmd_t  cmd_out
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RD     = 3'd1;
    localparam logic [2:0] S_CHK    = 3'd2;
    localparam logic [2:0] S_SPLIT  = 3'd3;
    localparam logic [2:0] S_APPEND = 3'd4;
    localparam logic [2:0] S_FREE   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       idle, out_free;

    assign idle     = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // A heap_key write goes ahead of a waiting request.
    assign in_stall  = !idle || cfg_valid;
    assign cfg_ready = idle;
    assign out_valid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd_out    = '0;
        cmd_out.cfg_wr = idle && cfg_valid;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !cfg_valid)
                begin
                    cmd_out.load = 1'b1;
                    state_next   = S_RD;
                end
            end
            S_RD:
            begin
                // The header at the walk position is read at this edge.
                if (sts.is_free)
                begin
                    state_next = S_FREE;
                end
                else if (sts.in_chain)
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_CHK:
            begin
                if (sts.fit)
                begin
                    cmd_out.take = 1'b1;
                    state_next   = S_SPLIT;
                end
                else
                begin
                    cmd_out.step = 1'b1;
                    state_next   = S_RD;
                end
            end
            S_SPLIT:
            begin
                cmd_out.split = 1'b1;
                state_next    = S_DONE;
            end
            S_APPEND:
            begin
                cmd_out.append = 1'b1;
                state_next     = S_DONE;
            end
            S_FREE:
            begin
                cmd_out.free_op = 1'b1;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd_out.publish = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on publish, cleared when the result is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd_out.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // One request at a time: an accepted request closes the input.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second request accepted while one is in work");

    // A result appears only when the sequencer finishes a request.
    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result valid without a finished request");

    // A free request never walks the header chain.
    a_free_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD && sts.is_free) |=> (state_reg == S_FREE))
        else $error("free request entered the header walk");

endmodule

[rtl/core/first_fit_block_allocator_top.sv]
// Top level of the first-fit block allocator: controller plus datapath.
//
//  channel  direction  handshake            payload
//  input    in         in_valid / in_stall  cmd, request_size, pointer_key, pointer_offset
//  output   out        out_valid / out_stall status, block_offset, block_key
//  config   in         cfg_valid / cfg_ready cfg_data (heap_key)
//
// A free passes from acceptance through the read, free and done states to the output
// register. An allocate reads and then checks each header in turn until one fits; it
// then claims that header, writes any split remainder and finishes. An append or a
// failure follows a walk to the end of the chain, reading headers through registered ports.
// A new request is accepted the cycle after the previous result enters the output
// register, even while that result is stalled; a pending heap_key write goes first.
// Reset clears the arena end and the heap key; the header memory is not cleared.
module first_fit_block_allocator_top #(
    parameter int ARENA_BYTES  = ffba_pkg::ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               cmd,
    input  logic [ffba_pkg::REQ_W-1:0]         request_size,
    input  logic [ffba_pkg::KEY_W-1:0]         pointer_key,
    input  logic [$clog2(ARENA_BYTES):0]       pointer_offset,
    output logic                               out_valid,
    input  logic                               out_stall,
    output ffba_pkg::status_t                  status,
    output logic [$clog2(ARENA_BYTES):0]       block_offset,
    output logic [ffba_pkg::KEY_W-1:0]         block_key,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ffba_pkg::KEY_W-1:0]         cfg_data
);

    ffba_pkg::ffba_cmd_t ctl_cmd;
    ffba_pkg::ffba_sts_t dp_sts;

    // Sequencing and handshakes.
    ffba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .sts       (dp_sts),
        .cmd_out   (ctl_cmd)
    );

    // Header memories, walk arithmetic and result registers.
    ffba_dpath #(
        .ARENA_BYTES  (ARENA_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_in         (ctl_cmd),
        .sts            (dp_sts),
        .cmd            (cmd),
        .request_size   (request_size),
        .pointer_key    (pointer_key),
        .pointer_offset (pointer_offset),
        .cfg_data       (cfg_data),
        .status         (status),
        .block_offset   (block_offset),
        .block_key      (block_key)
    );

endmodule

[tb/testbench.sv]
// Self-checking testbench for the first-fit block allocator top level.
`timescale 1ns / 100ps

module testbench;

    localparam int ARENA       = ffba_pkg::ARENA_BYTES_DEF;
    localparam int HDR         = ffba_pkg::HEADER_BYTES_DEF;
    localparam int REQ_W       = ffba_pkg::REQ_W;
    localparam int KEY_W       = ffba_pkg::KEY_W;
    localparam int OFF_W       = $clog2(ARENA) + 1;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 90;
    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        ffba_pkg::status_t  status;
        logic [OFF_W-1:0]   offset;
        logic [KEY_W-1:0]   key;
    } alloc_result_t;

    typedef enum logic [1:0] {ROW_ALLOC, ROW_FREE, ROW_SET_KEY} row_kind_t;

    typedef struct {
        row_kind_t      kind;
        int             size;
        bit [KEY_W-1:0] key;
        int             off;
        bit             typed;
        alloc_result_t  want;
    } plan_row_t;

    // Clock, reset and block ports; every input starts at a known value.
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                cmd = ffba_pkg::CMD_ALLOC;
    logic [REQ_W-1:0]    request_size = '0;
    logic [KEY_W-1:0]    pointer_key = '0;
    logic [OFF_W-1:0]    pointer_offset = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    ffba_pkg::status_t   status;
    logic [OFF_W-1:0]    block_offset;
    logic [KEY_W-1:0]    block_key;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [KEY_W-1:0]    cfg_data = '0;

    // Arena image kept by the predictor.
    bit [REQ_W-1:0]      size_mem [ARENA];
    bit                  used_mem [ARENA];
    bit                  ever_written [ARENA];
    int                  written_spots [$];
    int                  chain_end = 0;
    bit [KEY_W-1:0]      heap_key_model = '0;

    alloc_result_t       expected_results [$];
    plan_row_t           plan [$];
    int                  live_ptrs [$];
    int                  freed_ptrs [$];
    bit                  quiet = 1'b0;
    int                  error_count = 0;
    int                  results_seen = 0;
    int                  n_placed = 0;
    int                  n_full = 0;
    int                  n_freed = 0;
    int                  n_rejected = 0;
    int                  n_key_writes = 0;

    first_fit_block_allocator_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .request_size   (request_size),
        .pointer_key    (pointer_key),
        .pointer_offset (pointer_offset),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .block_offset   (block_offset),
        .block_key      (block_key),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    function automatic void log_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR at %0t: %s", $time, msg);
    endfunction

    // Remember every header position the block has written since reset.
    function automatic void note_header(int pos);
        if (!ever_written[pos])
        begin
            ever_written[pos] = 1'b1;
            written_spots.push_back(pos);
        end
    endfunction

    // First-fit allocate or keyed free against the arena image.
    function automatic alloc_result_t predict_request(logic c, logic [REQ_W-1:0] req,
                                                      logic [KEY_W-1:0] pkey,
                                                      logic [OFF_W-1:0] poff);
        alloc_result_t res;
        int pos;
        int sz;
        int split;
        res = '{status: ffba_pkg::ST_DONE, offset: '0, key: '0};
        if (c == ffba_pkg::CMD_FREE)
        begin
            if ((pkey == 0 && poff == 0) || pkey != heap_key_model)
            begin
                res.status = ffba_pkg::ST_REJECT;
                n_rejected++;
            end
            else
            begin
                if (poff >= HDR && int'(poff) - HDR < ARENA)
                    used_mem[int'(poff) - HDR] = 1'b0;
                n_freed++;
            end
            return res;
        end
        // Walk the chain for the first free block that fits exactly or can be split.
        pos = 0;
        while (pos < chain_end && pos < ARENA)
        begin
            sz = size_mem[pos];
            if (!used_mem[pos] && (sz == int'(req) || sz >= int'(req) + HDR))
            begin
                if (sz != int'(req))
                begin
                    split = pos + HDR + int'(req);
                    if (split < ARENA)
                    begin
                        used_mem[split] = 1'b0;
                        size_mem[split] = REQ_W'(sz - int'(req) - HDR);
                        note_header(split);
                    end
                end
                used_mem[pos] = 1'b1;
                size_mem[pos] = req;
                res.offset = OFF_W'(pos + HDR);
                res.key = heap_key_model;
                n_placed++;
                return res;
            end
            pos += HDR + sz;
        end
        // No fit: append at the end of the chain, if room is left.
        if (int'(req) + HDR > ARENA - chain_end)
        begin
            res.status = ffba_pkg::ST_NOSPACE;
            n_full++;
            return res;
        end
        pos = chain_end;
        used_mem[pos] = 1'b1;
        size_mem[pos] = req;
        note_header(pos);
        chain_end = pos + HDR + int'(req);
        res.offset = OFF_W'(pos + HDR);
        res.key = heap_key_model;
        n_placed++;
        return res;
    endfunction

    task automatic add_row(row_kind_t kind, int size, bit [KEY_W-1:0] key, int off,
                           bit typed, ffba_pkg::status_t st, int want_off,
                           bit [KEY_W-1:0] want_key);
        plan_row_t r;
        r.kind = kind;
        r.size = size;
        r.key = key;
        r.off = off;
        r.typed = typed;
        r.want = '{status: st, offset: OFF_W'(want_off), key: want_key};
        plan.push_back(r);
    endtask

    // Present one request and hold it until it is accepted.
    task automatic send_request(logic c, logic [REQ_W-1:0] sz, logic [KEY_W-1:0] k,
                                logic [OFF_W-1:0] o, bit typed, alloc_result_t typed_res,
                                output alloc_result_t predicted);
        in_valid <= 1'b1;
        cmd <= c;
        request_size <= sz;
        pointer_key <= k;
        pointer_offset <= o;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_request(c, sz, k, o);
        expected_results.push_back(typed ? typed_res : predicted);
    endtask

    // Random gap between requests.
    task automatic pause_input();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Change the heap key once the block is idle; this empties the arena.
    task automatic write_heap_key(bit [KEY_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        heap_key_model = value;
        chain_end = 0;
        live_ptrs.delete();
        freed_ptrs.delete();
        n_key_writes++;
    endtask

    // Output stall in random bursts, none while quiet.
    initial
    begin
        int n;
        n = 1;
        forever
        begin
            repeat (n) @(posedge clk);
            if (quiet)
            begin
                out_stall <= 1'b0;
                n = 1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < 35);
                n = $urandom_range(1, 15);
            end
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        alloc_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                log_error($sformatf("unexpected result status=%0d offset=%0d key=%h",
                                    status, block_offset, block_key));
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status || block_offset !== want.offset ||
                    block_key !== want.key)
                    log_error($sformatf({"result mismatch: expected status=%0d offset=%0d ",
                                         "key=%h, got status=%0d offset=%0d key=%h"},
                                        want.status, want.offset, want.key,
                                        status, block_offset, block_key));
            end
        end
    end

    // Stimulus: directed plan, then random phases under different heap keys.
    initial
    begin
        alloc_result_t res;
        alloc_result_t none;
        bit [KEY_W-1:0] phase_keys [NUM_PHASES];
        bit [KEY_W-1:0] k;
        int pick;
        int sel;
        int sz;
        int off;
        int idx;
        int pos;
        int free_spots [$];
        logic c;

        none = '0;
        phase_keys[0] = 32'h0000_0000;
        phase_keys[1] = 32'h0000_0001;
        phase_keys[2] = $urandom;
        phase_keys[3] = 32'h8000_0000;
        phase_keys[4] = $urandom;
        phase_keys[5] = 32'hFFFF_FFFF;

        // Heap key is zero after reset.
        add_row(ROW_ALLOC, 0, 0, 0, 1, ffba_pkg::ST_DONE, HDR, 0);
        add_row(ROW_ALLOC, 4080, 0, 0, 1, ffba_pkg::ST_NOSPACE, 0, 0);
        // Null pointer, foreign keys, an offset inside the first header, and a free of the first block.
        add_row(ROW_FREE, 0, 0, 0, 1, ffba_pkg::ST_REJECT, 0, 0);
        add_row(ROW_FREE, 0, 1, HDR, 1, ffba_pkg::ST_REJECT, 0, 0);
        add_row(ROW_FREE, 0, 32'hFFFF_FFFF, ARENA, 1, ffba_pkg::ST_REJECT, 0, 0);
        add_row(ROW_FREE, 0, 0, 5, 1, ffba_pkg::ST_DONE, 0, 0);
        add_row(ROW_FREE, 0, 0, HDR, 1, ffba_pkg::ST_DONE, 0, 0);
        // Exact reuse, append, split, exact fit of the split remainder, and a refused append.
        add_row(ROW_ALLOC, 0, 0, 0, 0, ffba_pkg::ST_DONE, 0, 0);
        add_row(ROW_ALLOC, 100, 0, 0, 0, ffba_pkg::ST_DONE, 0, 0);
        add_row(ROW_FREE, 0, 0, 32, 1, ffba_pkg::ST_DONE, 0, 0);
        add_row(ROW_ALLOC, 40, 0, 0, 0, ffba_pkg::ST_DONE, 0, 0);
        add_row(ROW_ALLOC, 44, 0, 0, 0, ffba_pkg::ST_DONE, 0, 0);
        add_row(ROW_ALLOC, 4000, 0, 0, 0, ffba_pkg::ST_DONE, 0, 0);
        // Double free goes through unchecked.
        add_row(ROW_FREE, 0, 0, 32, 1, ffba_pkg::ST_DONE, 0, 0);
        add_row(ROW_FREE, 0, 0, 32, 1, ffba_pkg::ST_DONE, 0, 0);
        // New key empties the arena; the full arena takes one maximal block.
        add_row(ROW_SET_KEY, 0, 32'hFFFF_FFFF, 0, 0, ffba_pkg::ST_DONE, 0, 0);
        add_row(ROW_ALLOC, 4080, 0, 0, 1, ffba_pkg::ST_DONE, HDR, 32'hFFFF_FFFF);
        // Free at a stale header position that now lies inside a payload.
        add_row(ROW_FREE, 0, 32'hFFFF_FFFF, 88, 1, ffba_pkg::ST_DONE, 0, 0);
        add_row(ROW_ALLOC, 0, 0, 0, 1, ffba_pkg::ST_NOSPACE, 0, 0);
        add_row(ROW_FREE, 0, 32'hFFFF_FFFF, HDR, 1, ffba_pkg::ST_DONE, 0, 0);
        add_row(ROW_ALLOC, 4080, 0, 0, 0, ffba_pkg::ST_DONE, 0, 0);
        add_row(ROW_FREE, 0, 0, 0, 1, ffba_pkg::ST_REJECT, 0, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_SET_KEY)
                write_heap_key(plan[i].key);
            else
            begin
                send_request(plan[i].kind == ROW_FREE ? ffba_pkg::CMD_FREE
                                                      : ffba_pkg::CMD_ALLOC,
                             REQ_W'(plan[i].size), plan[i].key, OFF_W'(plan[i].off),
                             plan[i].typed, plan[i].want, res);
                pause_input();
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_heap_key(phase_keys[ph]);
            quiet = (ph == NUM_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                k = $urandom;
                off = $urandom_range(0, ARENA);
                sz = $urandom_range(0, 64);
                c = ffba_pkg::CMD_FREE;
                if (pick < 55)
                begin
                    // Allocate: mostly small, some sized to a free block, a few huge.
                    c = ffba_pkg::CMD_ALLOC;
                    sel = $urandom_range(0, 9);
                    if (sel >= 5 && sel < 7)
                        sz = $urandom_range(0, 400);
                    else if (sel == 7)
                    begin
                        free_spots.delete();
                        pos = 0;
                        while (pos < chain_end)
                        begin
                            if (!used_mem[pos])
                                free_spots.push_back(pos);
                            pos += HDR + size_mem[pos];
                        end
                        if (free_spots.size() != 0)
                        begin
                            sz = size_mem[free_spots[$urandom_range(0, free_spots.size() - 1)]];
                            if (sz >= HDR && $urandom_range(0, 1) == 1)
                                sz = $urandom_range(0, sz - HDR);
                        end
                    end
                    else if (sel == 8)
                        sz = $urandom_range(1000, 4080);
                    else if (sel == 9)
                        sz = $urandom_range(0, 4080);
                end
                else if (pick < 85)
                begin
                    // Free a live block, now and then one already freed.
                    k = heap_key_model;
                    if (live_ptrs.size() != 0 &&
                        (freed_ptrs.size() == 0 || $urandom_range(0, 5) != 0))
                    begin
                        idx = $urandom_range(0, live_ptrs.size() - 1);
                        off = live_ptrs[idx];
                        live_ptrs.delete(idx);
                        freed_ptrs.push_back(off);
                    end
                    else if (freed_ptrs.size() != 0)
                        off = freed_ptrs[$urandom_range(0, freed_ptrs.size() - 1)];
                    else
                        off = $urandom_range(0, HDR - 1);
                end
                else
                begin
                    // Malformed frees.
                    sel = $urandom_range(0, 4);
                    if (k == heap_key_model)
                        k = ~k;
                    if (sel == 0)
                    begin
                        k = '0;
                        off = 0;
                    end
                    else if (sel == 2)
                    begin
                        k = heap_key_model;
                        off = $urandom_range(0, HDR - 1);
                    end
                    else if (sel == 3)
                    begin
                        k = heap_key_model;
                        off = (written_spots.size() != 0) ?
                              written_spots[$urandom_range(0, written_spots.size() - 1)] + HDR :
                              $urandom_range(0, HDR - 1);
                    end
                    else if (sel == 4)
                        off = ARENA;
                end
                send_request(c, REQ_W'(sz), k, OFF_W'(off), 1'b0, none, res);
                if (c == ffba_pkg::CMD_ALLOC && res.status == ffba_pkg::ST_DONE)
                    live_ptrs.push_back(int'(res.offset));
                pause_input();
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (expected_results.size() != 0)
            log_error($sformatf("%0d results never arrived", expected_results.size()));

        $display("summary: %0d results checked over %0d heap keys; %0d blocks placed, %0d refused",
                 results_seen, n_key_writes, n_placed, n_full);
        $display("summary: %0d frees applied, %0d rejected, %0d mismatches",
                 n_freed, n_rejected, error_count);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

[first_fit_block_allocator_top.f]
rtl/core/ffba_pkg.sv
rtl/core/ffba_dpath.sv
rtl/core/ffba_ctrl.sv
rtl/core/first_fit_block_allocator_top.sv
tb/testbench.sv
